// ===== hdl/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the button debounce block
// Holds the configuration bundle, its reset values, and the phase, command,
// button and register index codes.
// ----------------------------------------------------------------------------
package bda_pkg;

	localparam int unsigned PeriodWidth  = 16;
	localparam int unsigned DivWidth     = 3;
	localparam int unsigned CountWidth   = 4;
	localparam int unsigned CfgIdxWidth  = 2;
	localparam int unsigned CfgDataWidth = 16;

	typedef struct packed {
		logic [PeriodWidth-1:0] settle_period;
		logic [PeriodWidth-1:0] repeat_period;
		logic [DivWidth-1:0]    repeat_divisor;
		logic [CountWidth-1:0]  count_limit;
	} cfg_t;

	localparam logic [PeriodWidth-1:0] SETTLE_RESET  = 16'd2462;
	localparam logic [PeriodWidth-1:0] REPEAT_RESET  = 16'd1845;
	localparam logic [DivWidth-1:0]    DIVISOR_RESET = 3'd4;
	localparam logic [CountWidth-1:0]  LIMIT_RESET   = 4'd8;

	// Register indexes on the configuration port.
	localparam logic [CfgIdxWidth-1:0] REG_SETTLE  = 2'd0;
	localparam logic [CfgIdxWidth-1:0] REG_REPEAT  = 2'd1;
	localparam logic [CfgIdxWidth-1:0] REG_DIVISOR = 2'd2;
	localparam logic [CfgIdxWidth-1:0] REG_LIMIT   = 2'd3;

	// Phase codes.
	localparam logic [1:0] PH_WAIT  = 2'd0;
	localparam logic [1:0] PH_INIT  = 2'd1;
	localparam logic [1:0] PH_HELD  = 2'd2;
	localparam logic [1:0] PH_FINAL = 2'd3;

	// Command codes.
	localparam logic [1:0] CMD_PRESS = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_POLL  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	// Button codes.
	localparam logic [1:0] BTN_NONE  = 2'd0;
	localparam logic [1:0] BTN_LEFT  = 2'd1;
	localparam logic [1:0] BTN_RIGHT = 2'd2;

	// Counter advance: wraps to zero from the limit or above.
	function automatic logic [CountWidth-1:0] advance_count(
		input logic [CountWidth-1:0] count,
		input logic [CountWidth-1:0] limit
	);
		logic [CountWidth-1:0] result;
		if (count < limit) begin
			result = count + 1'b1;
		end else begin
			result = '0;
		end
		return result;
	endfunction

endpackage

// ===== hdl/button_debounce_autorepeat.sv =====
// ----------------------------------------------------------------------------
// button_debounce_autorepeat: two-button debounce and auto-repeat controller
// Top level with the input register, the state update and the result register.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the input channel (in_valid, in_stall) carrying cmd,
// which_button and the two pin levels. Each request produces exactly one
// result on the output channel (out_valid, out_stall) with the counter,
// the phase after the request and the two poll flags.
// A request is captured in an input register; the state update runs once the
// output register is empty or not stalled, and its result is written to the
// output register, where it can be taken when out_stall is low. One request
// is accepted every cycle while the receiver does not stall; the rate is set
// by the state update, which is combinational.
// When the receiver stalls, the output register holds its result and the
// input register keeps one more request; after that in_stall is raised until
// the output drains.
// Configuration registers are written through cfg_we, cfg_index and cfg_data.
// The user must do so only while no request is in flight; nothing checks it.
// Reset clears valid bits and state, loads default periods, divisor, limit.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        cmd,
	input  logic [1:0]                        which_button,
	input  logic                              left_level,
	input  logic                              right_level,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bda_pkg::CountWidth-1:0]    count_value,
	output logic [1:0]                        phase_code,
	output logic                              left_once,
	output logic                              right_once,
	input  logic                              cfg_we,
	input  logic [bda_pkg::CfgIdxWidth-1:0]  cfg_index,
	input  logic [bda_pkg::CfgDataWidth-1:0] cfg_data
);
	import bda_pkg::*;

	cfg_t cfg;

	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [1:0] which_button_s1;
	logic       left_level_s1;
	logic       right_level_s1;

	logic                  valid_s2;
	logic [CountWidth-1:0] count_value_s2;
	logic [1:0]            phase_code_s2;
	logic                  left_once_s2;
	logic                  right_once_s2;

	logic                  step_en;
	logic                  in_take;
	logic [CountWidth-1:0] count_next;
	logic [1:0]            phase_next;
	logic                  left_once_next;
	logic                  right_once_next;

	assign step_en  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !step_en;
	assign in_take  = in_valid && !in_stall;

	bda_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bda_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (step_en),
		.cfg          (cfg),
		.cmd          (cmd_s1),
		.which_button (which_button_s1),
		.left_level   (left_level_s1),
		.right_level  (right_level_s1),
		.count_value  (count_next),
		.phase_code   (phase_next),
		.left_once    (left_once_next),
		.right_once   (right_once_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1          <= cmd;
			which_button_s1 <= which_button;
			left_level_s1   <= left_level;
			right_level_s1  <= right_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step_en) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			count_value_s2 <= count_next;
			phase_code_s2  <= phase_next;
			left_once_s2   <= left_once_next;
			right_once_s2  <= right_once_next;
		end
	end

	assign out_valid   = valid_s2;
	assign count_value = count_value_s2;
	assign phase_code  = phase_code_s2;
	assign left_once   = left_once_s2;
	assign right_once  = right_once_s2;

endmodule

// ===== hdl/bda_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bda_cfg_regs: configuration registers
// Write-only register file for the settle, repeat, divisor and limit values.
// ----------------------------------------------------------------------------
module bda_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bda_pkg::CfgIdxWidth-1:0]  cfg_index,
	input  logic [bda_pkg::CfgDataWidth-1:0] cfg_data,
	output bda_pkg::cfg_t                     cfg
);
	import bda_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_period  <= SETTLE_RESET;
			cfg_q.repeat_period  <= REPEAT_RESET;
			cfg_q.repeat_divisor <= DIVISOR_RESET;
			cfg_q.count_limit    <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SETTLE:  cfg_q.settle_period  <= cfg_data[PeriodWidth-1:0];
				REG_REPEAT:  cfg_q.repeat_period  <= cfg_data[PeriodWidth-1:0];
				REG_DIVISOR: cfg_q.repeat_divisor <= cfg_data[DivWidth-1:0];
				REG_LIMIT:   cfg_q.count_limit    <= cfg_data[CountWidth-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/bda_step.sv =====
// ----------------------------------------------------------------------------
// bda_step: debounce and auto-repeat state update
// Holds the controller state and computes the next state and the result of
// one request in a single pass. State is written when step_en is high.
// ----------------------------------------------------------------------------
module bda_step (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step_en,
	input  bda_pkg::cfg_t                   cfg,
	input  logic [1:0]                      cmd,
	input  logic [1:0]                      which_button,
	input  logic                            left_level,
	input  logic                            right_level,
	output logic [bda_pkg::CountWidth-1:0]  count_value,
	output logic [1:0]                      phase_code,
	output logic                            left_once,
	output logic                            right_once
);
	import bda_pkg::*;

	logic [1:0]             phase_q;
	logic [1:0]             active_button_q;
	logic [DivWidth-1:0]    held_checks_q;
	logic [CountWidth-1:0]  press_count_q;
	logic                   pending_flag_q;
	logic [PeriodWidth-1:0] tick_countdown_q;

	logic [1:0]             phase_d;
	logic [1:0]             active_button_d;
	logic [DivWidth-1:0]    held_checks_d;
	logic [CountWidth-1:0]  press_count_d;
	logic                   pending_flag_d;
	logic [PeriodWidth-1:0] tick_countdown_d;
	logic                   left_once_d;
	logic                   right_once_d;
	logic                   released;

	assign released = (active_button_q == BTN_RIGHT && right_level) ||
		(active_button_q == BTN_LEFT && left_level);

	always_comb begin
		phase_d          = phase_q;
		active_button_d  = active_button_q;
		held_checks_d    = held_checks_q;
		press_count_d    = press_count_q;
		pending_flag_d   = pending_flag_q;
		tick_countdown_d = tick_countdown_q;
		left_once_d      = 1'b0;
		right_once_d     = 1'b0;
		unique case (cmd)
			CMD_PRESS: begin
				// Presses are ignored outside the waiting phase.
				if (phase_q == PH_WAIT) begin
					if (which_button == BTN_LEFT) begin
						press_count_d   = advance_count(press_count_q, cfg.count_limit);
						active_button_d = BTN_LEFT;
					end else if (which_button == BTN_RIGHT) begin
						active_button_d = BTN_RIGHT;
					end
					tick_countdown_d = cfg.settle_period;
					held_checks_d    = '0;
					phase_d          = PH_INIT;
					pending_flag_d   = 1'b1;
				end
			end
			CMD_TICK: begin
				if (phase_q != PH_WAIT) begin
					if (tick_countdown_q > 16'd1) begin
						tick_countdown_d = tick_countdown_q - 1'b1;
					end else begin
						unique case (phase_q)
							PH_INIT: begin
								tick_countdown_d = cfg.repeat_period;
								phase_d          = PH_HELD;
							end
							PH_HELD: begin
								if (released) begin
									tick_countdown_d = cfg.settle_period;
									phase_d          = PH_FINAL;
								end else begin
									tick_countdown_d = cfg.repeat_period;
									if (held_checks_q == cfg.repeat_divisor) begin
										held_checks_d = '0;
										if (active_button_q == BTN_LEFT) begin
											press_count_d = advance_count(press_count_q,
												cfg.count_limit);
										end else begin
											press_count_d = '0;
										end
									end else begin
										held_checks_d = held_checks_q + 1'b1;
									end
								end
							end
							PH_FINAL: begin
								tick_countdown_d = '0;
								phase_d          = PH_WAIT;
								active_button_d  = BTN_NONE;
							end
							default: ;
						endcase
					end
				end
			end
			CMD_POLL: begin
				// The flag is only cleared when a known button reports it.
				if (pending_flag_q) begin
					if (active_button_q == BTN_LEFT) begin
						left_once_d    = 1'b1;
						pending_flag_d = 1'b0;
					end else if (active_button_q == BTN_RIGHT) begin
						right_once_d   = 1'b1;
						pending_flag_d = 1'b0;
					end
				end
			end
			default: begin
				press_count_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_WAIT;
			active_button_q  <= BTN_NONE;
			held_checks_q    <= '0;
			press_count_q    <= '0;
			pending_flag_q   <= 1'b0;
			tick_countdown_q <= '0;
		end else if (step_en) begin
			phase_q          <= phase_d;
			active_button_q  <= active_button_d;
			held_checks_q    <= held_checks_d;
			press_count_q    <= press_count_d;
			pending_flag_q   <= pending_flag_d;
			tick_countdown_q <= tick_countdown_d;
		end
	end

	assign count_value = press_count_d;
	assign phase_code  = phase_d;
	assign left_once   = left_once_d;
	assign right_once  = right_once_d;

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(phase_q) && $stable(press_count_q) && $stable(pending_flag_q))
		else $error("state changed without a request");

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!(left_once_d && right_once_d))
		else $error("both one-shot flags reported together");

	a_poll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && cmd == CMD_POLL && (left_once_d || right_once_d) |=> !pending_flag_q)
		else $error("reported one-shot flag was not cleared");

	a_press_starts: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && cmd == CMD_PRESS && phase_q == PH_WAIT |=>
		phase_q == PH_INIT && pending_flag_q && held_checks_q == '0)
		else $error("press in waiting phase did not start the settle");

	a_wait_forgets: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FINAL && phase_d == PH_WAIT && step_en |=>
		active_button_q == BTN_NONE && tick_countdown_q == '0)
		else $error("return to waiting kept the button or countdown");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two-button debounce and repeat block
// Drives press, tick, poll and clear requests with random gaps and output
// stalls. A scoreboard class tracks the phase, countdown, counter and one-shot
// flag of the controller, and it checks every result against its prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import bda_pkg::*;

	typedef struct {
		logic [CountWidth-1:0] count;
		logic [1:0]            stage;
		logic                  lft;
		logic                  rgt;
	} outcome_t;

	class press_tracker;
		logic [PeriodWidth-1:0] settle_len;
		logic [PeriodWidth-1:0] repeat_len;
		logic [DivWidth-1:0]    divisor;
		logic [CountWidth-1:0]  wrap_at;

		logic [1:0]             stage;
		logic [1:0]             owner;
		logic [DivWidth-1:0]    checks;
		logic [CountWidth-1:0]  presses;
		logic                   flag;
		logic [PeriodWidth-1:0] timer;

		outcome_t awaited[$];
		int errors;
		int requests;
		int results;
		int repeats_fired;
		int releases;
		int flags_seen;

		function new();
			settle_len = SETTLE_RESET;
			repeat_len = REPEAT_RESET;
			divisor    = DIVISOR_RESET;
			wrap_at    = LIMIT_RESET;
			stage      = PH_WAIT;
			owner      = BTN_NONE;
			checks     = '0;
			presses    = '0;
			flag       = 1'b0;
			timer      = '0;
		endfunction

		function void set_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
			case (idx)
				REG_SETTLE:  settle_len = val;
				REG_REPEAT:  repeat_len = val;
				REG_DIVISOR: divisor = val[DivWidth-1:0];
				default:     wrap_at = val[CountWidth-1:0];
			endcase
		endfunction

		function void bump();
			presses = (presses < wrap_at) ? presses + 1'b1 : '0;
		endfunction

		// Runs the action of the current phase when its countdown runs out.
		function void expire(logic lft, logic rgt);
			case (stage)
				PH_INIT: begin
					timer = repeat_len;
					stage = PH_HELD;
				end
				PH_HELD: begin
					if ((owner == BTN_RIGHT && rgt) || (owner == BTN_LEFT && lft)) begin
						timer = settle_len;
						stage = PH_FINAL;
						releases++;
					end else begin
						timer = repeat_len;
						if (checks == divisor) begin
							checks = '0;
							repeats_fired++;
							if (owner == BTN_LEFT) bump();
							else presses = '0;
						end else begin
							checks = checks + 1'b1;
						end
					end
				end
				PH_FINAL: begin
					timer = '0;
					stage = PH_WAIT;
					owner = BTN_NONE;
				end
				default: ;
			endcase
		endfunction

		function void note_request(logic [1:0] op, logic [1:0] btn, logic lft, logic rgt);
			outcome_t r;
			r.lft = 1'b0;
			r.rgt = 1'b0;
			requests++;
			case (op)
				CMD_PRESS: begin
					if (stage == PH_WAIT) begin
						if (btn == BTN_LEFT) begin
							bump();
							owner = BTN_LEFT;
						end else if (btn == BTN_RIGHT) begin
							owner = BTN_RIGHT;
						end
						timer  = settle_len;
						checks = '0;
						stage  = PH_INIT;
						flag   = 1'b1;
					end
				end
				CMD_TICK: begin
					if (stage != PH_WAIT) begin
						if (timer > 1) timer = timer - 1'b1;
						else expire(lft, rgt);
					end
				end
				CMD_POLL: begin
					if (flag) begin
						if (owner == BTN_LEFT) begin
							r.lft = 1'b1;
							flag = 1'b0;
							flags_seen++;
						end else if (owner == BTN_RIGHT) begin
							r.rgt = 1'b1;
							flag = 1'b0;
							flags_seen++;
						end
					end
				end
				default: presses = '0;
			endcase
			r.count = presses;
			r.stage = stage;
			awaited.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [CountWidth-1:0] count, logic [1:0] stg, logic lft, logic rgt);
			outcome_t w;
			if (awaited.size() == 0) begin
				report($sformatf("result with no request outstanding (count %0d phase %0d)",
					count, stg));
			end else begin
				w = awaited.pop_front();
				results++;
				if (count !== w.count)
					report($sformatf("count_value %0d, predicted %0d", count, w.count));
				if (stg !== w.stage)
					report($sformatf("phase_code %0d, predicted %0d", stg, w.stage));
				if (lft !== w.lft)
					report($sformatf("left_once %0b, predicted %0b", lft, w.lft));
				if (rgt !== w.rgt)
					report($sformatf("right_once %0b, predicted %0b", rgt, w.rgt));
			end
		endtask

		task flush_leftovers();
			while (awaited.size() != 0) begin
				void'(awaited.pop_front());
				report("predicted result never arrived");
			end
		endtask
	endclass

	localparam int WatchdogLimit = 1000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [1:0]              cmd = CMD_POLL;
	logic [1:0]              which_button = BTN_NONE;
	logic                    left_level = 1'b1;
	logic                    right_level = 1'b1;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [CountWidth-1:0]   count_value;
	logic [1:0]              phase_code;
	logic                    left_once;
	logic                    right_once;
	logic                    cfg_we = 1'b0;
	logic [CfgIdxWidth-1:0]  cfg_index = REG_SETTLE;
	logic [CfgDataWidth-1:0] cfg_data = '0;

	bit calm = 1'b0;
	logic hold_l = 1'b1;
	logic hold_r = 1'b1;
	int idle_cycles = 0;
	press_tracker tracker = new();

	button_debounce_autorepeat uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.which_button(which_button),
		.left_level(left_level),
		.right_level(right_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.count_value(count_value),
		.phase_code(phase_code),
		.left_once(left_once),
		.right_once(right_once),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 29);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			tracker.check_result(count_value, phase_code, left_once, right_once);
		end
	end

	// Ends the run when neither channel has moved for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WatchdogLimit) begin
				$display("Timeout: no request or result moved for %0d cycles", idle_cycles);
				$display("button_debounce_autorepeat: mismatch");
				$finish;
			end
		end
	end

	task automatic send(input logic [1:0] op, input logic [1:0] btn,
			input logic lft, input logic rgt);
		while (!calm && $urandom_range(99) < 29) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		cmd          <= op;
		which_button <= btn;
		left_level   <= lft;
		right_level  <= rgt;
		do @(posedge clk); while (in_stall);
		tracker.note_request(op, btn, lft, rgt);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
			input logic [CfgDataWidth-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(idx, val);
	endtask

	task automatic apply_setting(input logic [PeriodWidth-1:0] settle_len,
			input logic [PeriodWidth-1:0] repeat_len,
			input logic [DivWidth-1:0] divisor, input logic [CountWidth-1:0] wrap_at);
		write_reg(REG_SETTLE, settle_len);
		write_reg(REG_REPEAT, repeat_len);
		write_reg(REG_DIVISOR, CfgDataWidth'(divisor));
		write_reg(REG_LIMIT, CfgDataWidth'(wrap_at));
	endtask

	// Pin levels stay put for stretches so that held phases run long enough
	// to fire repeats before the button is let go.
	task automatic random_requests(input int n, input bit any_button);
		logic [1:0] op;
		logic [1:0] btn;
		int pick;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 4) hold_l = !hold_l;
			if ($urandom_range(99) < 4) hold_r = !hold_r;
			pick = $urandom_range(99);
			if (pick < 15) op = CMD_PRESS;
			else if (pick < 75) op = CMD_TICK;
			else if (pick < 92) op = CMD_POLL;
			else op = CMD_CLEAR;
			btn = any_button ? 2'($urandom_range(3)) : 2'($urandom_range(2, 1));
			send(op, btn, hold_l, hold_r);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed walk through both buttons, polls, clears and repeats.
		apply_setting(16'd1, 16'd1, 3'd1, 4'd15);
		send(CMD_POLL, BTN_NONE, 1'b1, 1'b1);
		send(CMD_TICK, BTN_NONE, 1'b0, 1'b0);
		send(CMD_CLEAR, 2'd3, 1'b0, 1'b0);
		send(CMD_PRESS, BTN_LEFT, 1'b0, 1'b1);
		send(CMD_PRESS, BTN_RIGHT, 1'b0, 1'b1);
		send(CMD_POLL, BTN_NONE, 1'b0, 1'b1);
		send(CMD_POLL, BTN_NONE, 1'b0, 1'b1);
		send(CMD_TICK, BTN_NONE, 1'b0, 1'b0);
		send(CMD_TICK, BTN_NONE, 1'b0, 1'b0);
		send(CMD_TICK, BTN_NONE, 1'b0, 1'b0);
		send(CMD_CLEAR, BTN_NONE, 1'b0, 1'b0);
		send(CMD_TICK, BTN_NONE, 1'b1, 1'b0);
		send(CMD_TICK, BTN_NONE, 1'b1, 1'b0);
		send(CMD_POLL, BTN_NONE, 1'b1, 1'b1);
		send(CMD_PRESS, BTN_RIGHT, 1'b1, 1'b0);
		send(CMD_TICK, BTN_NONE, 1'b1, 1'b0);
		send(CMD_TICK, BTN_NONE, 1'b1, 1'b0);
		send(CMD_TICK, BTN_NONE, 1'b1, 1'b0);
		send(CMD_TICK, BTN_NONE, 1'b0, 1'b1);
		send(CMD_POLL, BTN_NONE, 1'b0, 1'b1);
		send(CMD_TICK, BTN_NONE, 1'b1, 1'b1);
		// The flag outlives the return to waiting but a poll no longer sees it.
		send(CMD_PRESS, BTN_RIGHT, 1'b1, 1'b1);
		send(CMD_TICK, BTN_NONE, 1'b1, 1'b1);
		send(CMD_TICK, BTN_NONE, 1'b1, 1'b1);
		send(CMD_TICK, BTN_NONE, 1'b1, 1'b1);
		send(CMD_POLL, BTN_NONE, 1'b1, 1'b1);
		wait_for_results();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: apply_setting(16'd1, 16'd1, 3'd0, 4'd0);
				1: apply_setting(16'hFFFF, 16'hFFFF, 3'd7, 4'd15);
				2: apply_setting(SETTLE_RESET, REPEAT_RESET, DIVISOR_RESET, LIMIT_RESET);
				3: apply_setting(16'd0, 16'd0, 3'd3, 4'd5);
				default: apply_setting(16'($urandom_range(6, 1)), 16'($urandom_range(4, 1)),
					3'($urandom_range(7)), 4'($urandom_range(15)));
			endcase
			calm = (p == 5);
			random_requests((p == 1 || p == 2) ? 80 : 200, 1'b0);
			if (p == 4) begin
				wait_for_results();
				random_requests(40, 1'b0);
			end
			wait_for_results();
		end
		calm = 1'b0;

		// A press of no known button leaves the block held for good, so it
		// comes last.
		apply_setting(16'd2, 16'd1, 3'd2, 4'd15);
		send(CMD_PRESS, BTN_NONE, 1'b1, 1'b1);
		send(CMD_PRESS, 2'd3, 1'b1, 1'b1);
		send(CMD_POLL, BTN_NONE, 1'b1, 1'b1);
		random_requests(45, 1'b1);
		wait_for_results();

		repeat (10) @(posedge clk);
		tracker.flush_leftovers();
		$display("Ran %0d requests and checked %0d results over ten register settings.",
			tracker.requests, tracker.results);
		$display("Saw %0d auto-repeats, %0d button releases and %0d one-shot flags.",
			tracker.repeats_fired, tracker.releases, tracker.flags_seen);
		if (tracker.errors == 0) begin
			$display("button_debounce_autorepeat: match");
		end else begin
			$display("button_debounce_autorepeat: mismatch");
		end
		$finish;
	end

endmodule
